@@ rtl/shts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Subnet host traffic statistics - shared package
// Request and result layouts, request codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package shts_pkg;

    localparam int HOST_ENTRIES_DEF = 256;
    localparam int COUNTER_BITS_DEF = 48;

    localparam int IP_W     = 32;
    localparam int OCT_W    = 40;
    localparam int OUT_W    = 48;
    localparam int SUM_W    = 64;
    localparam int TICK_W   = 16;
    localparam int ALPHA_W  = 9;
    localparam int ALPHA_FR = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [1:0] REQ_FLOW  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q8    = 2'd3;

    localparam logic [IP_W-1:0]    RST_SUBNET_BASE = 32'h0000_0000;
    localparam logic [IP_W-1:0]    RST_SUBNET_MASK = 32'hFFFF_FF00;
    localparam logic [TICK_W-1:0]  RST_INTERVAL_MS = 16'd1000;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_Q8    = 9'd26;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 9'd256;

    typedef struct packed {
        logic [1:0]       req_type;
        logic             is_flow_record;
        logic [IP_W-1:0]  src_ip;
        logic [IP_W-1:0]  dst_ip;
        logic [OCT_W-1:0] flow_octets;
        logic [IP_W-1:0]  query_ip;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] host_octets;
        logic [OUT_W-1:0] zero_avg_octets;
        logic             rolled_over;
        logic             out_of_range;
    } t_res;

    // write strobes into the host table
    typedef struct packed {
        logic valid_we;
        logic valid_val;
        logic cur_we;
        logic prev_we;
    } t_tbl_we;

endpackage
`default_nettype wire

@@ rtl/shts_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Subnet host traffic statistics - host table
// Valid, current-octet and last-interval-octet memories, one shared address,
// registered read data.
// ----------------------------------------------------------------------------
module shts_table #(
    parameter int HOST_ENTRIES = shts_pkg::HOST_ENTRIES_DEF,
    parameter int COUNTER_BITS = shts_pkg::COUNTER_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire [$clog2(HOST_ENTRIES)-1:0] i_addr,
    input  wire shts_pkg::t_tbl_we       i_we,
    input  wire [COUNTER_BITS-1:0]       i_wd_cur,
    input  wire [COUNTER_BITS-1:0]       i_wd_prev,
    output logic                         o_rd_valid,
    output logic [COUNTER_BITS-1:0]      o_rd_cur,
    output logic [COUNTER_BITS-1:0]      o_rd_prev
);

    logic                    r_valid_mem [HOST_ENTRIES];
    logic [COUNTER_BITS-1:0] r_cur_mem   [HOST_ENTRIES];
    logic [COUNTER_BITS-1:0] r_prev_mem  [HOST_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we.valid_we) begin
            r_valid_mem[i_addr] <= i_we.valid_val;
        end
        o_rd_valid <= r_valid_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.cur_we) begin
            r_cur_mem[i_addr] <= i_wd_cur;
        end
        o_rd_cur <= r_cur_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.prev_we) begin
            r_prev_mem[i_addr] <= i_wd_prev;
        end
        o_rd_prev <= r_prev_mem[i_addr];
    end

endmodule
`default_nettype wire

@@ rtl/shts_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Subnet host traffic statistics - iterative divider
// Restoring division of a 64-bit sum by a narrow count, one quotient bit
// per cycle; o_done pulses with the quotient ready.
// ----------------------------------------------------------------------------
module shts_div #(
    parameter int DIVISOR_BITS = 9
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [shts_pkg::SUM_W-1:0] i_dividend,
    input  wire [DIVISOR_BITS-1:0]    i_divisor,
    output logic                      o_done,
    output logic [shts_pkg::SUM_W-1:0] o_quotient
);

    localparam int SW = shts_pkg::SUM_W;
    localparam int CW = $clog2(SW);

    logic                    r_busy;
    logic [CW-1:0]           r_cnt;
    logic [SW-1:0]           r_quo;
    logic [DIVISOR_BITS-1:0] r_rem;
    logic [DIVISOR_BITS-1:0] r_div;

    logic [DIVISOR_BITS:0]   w_rem_sh;
    logic [DIVISOR_BITS:0]   w_diff;
    logic                    w_ge;

    assign w_rem_sh = {r_rem, r_quo[SW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};
    assign w_diff   = w_rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVISOR_BITS-1:0] : w_rem_sh[DIVISOR_BITS-1:0];
        end
    end

    assign o_quotient = r_quo;

endmodule
`default_nettype wire

@@ rtl/subnet_host_traffic_stats_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Subnet host traffic statistics - top level
// Per-host octet table for one watched subnet, interval rollover with an
// idle-host moving average, and host queries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_stall with payload i_in_req; each
//   request gives exactly one result on o_out_valid / i_out_stall.
//   One request is worked on at a time; o_in_stall is high while it runs.
//   Work per request: a flow record reads and then writes the table for each
//     of its addresses that is in the table; a query does one table read (none
//     without a lookup); a tick with rollover walks every entry with a read and a
//     write, runs the 64-step divider unless no host is idle, then the shared multiply.
//   A result waits in the output register while i_out_stall is high; the
//   next request is still taken, and its result is held back until the
//   output register frees up.
//   After reset the valid bits are swept clear, entry by entry, with
//   o_in_stall high; configuration writes are taken at any time and should
//   be made only while no request is in flight.
// ----------------------------------------------------------------------------
module subnet_host_traffic_stats_top #(
    parameter int HOST_ENTRIES = shts_pkg::HOST_ENTRIES_DEF,
    parameter int COUNTER_BITS = shts_pkg::COUNTER_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire shts_pkg::t_req              i_in_req,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output shts_pkg::t_res                   o_out_res,
    input  wire                              i_cfg_we,
    input  wire [shts_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [shts_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    localparam int IW = $clog2(HOST_ENTRIES);
    localparam int CW = $clog2(HOST_ENTRIES + 1);
    localparam int CB = COUNTER_BITS;
    localparam int SW = shts_pkg::SUM_W;
    localparam int OW = shts_pkg::OUT_W;
    localparam int AL = shts_pkg::ALPHA_W;
    localparam int FR = shts_pkg::ALPHA_FR;
    localparam int TW = shts_pkg::TICK_W;
    localparam int PW = CB + AL;
    localparam int AW = PW + 1;
    localparam logic [SW-1:0] CNT_MAX = {SW{1'b1}} >> (SW - CB);
    localparam logic [32:0]   HOST_LIM = 33'(HOST_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(HOST_ENTRIES - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_FRD  = 4'd2;
    localparam logic [3:0] S_FWR  = 4'd3;
    localparam logic [3:0] S_WRD  = 4'd4;
    localparam logic [3:0] S_WWR  = 4'd5;
    localparam logic [3:0] S_DIVS = 4'd6;
    localparam logic [3:0] S_DIVW = 4'd7;
    localparam logic [3:0] S_BL1  = 4'd8;
    localparam logic [3:0] S_BL2  = 4'd9;
    localparam logic [3:0] S_BL3  = 4'd10;
    localparam logic [3:0] S_QRD  = 4'd11;
    localparam logic [3:0] S_QRES = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    // configuration
    logic [31:0]   r_base;
    logic [31:0]   r_mask;
    logic [TW-1:0] r_interval;
    logic [AL-1:0] r_alpha;
    logic [AL-1:0] w_alpha_wr;

    // sequencer and working state
    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [IW-1:0] r_walk_idx;
    logic [IW-1:0] r_src_idx;
    logic [IW-1:0] r_dst_idx;
    logic          r_src_hit;
    logic          r_dst_hit;
    logic          r_phase;
    logic [CB-1:0] r_octs;
    logic [TW-1:0] r_tick;
    logic [SW-1:0] r_sum;
    logic [CW-1:0] r_idle;
    logic [CB-1:0] r_sample;
    logic [CB-1:0] r_avg;
    logic [AW-1:0] r_acc;

    // result being built
    logic          r_found;
    logic [OW-1:0] r_host;
    logic          r_rolled;
    logic          r_oor;

    // request decode
    logic          w_accept;
    logic          w_src_in;
    logic          w_src_fit;
    logic          w_dst_in;
    logic          w_dst_fit;
    logic          w_q_in;
    logic          w_q_fit;
    logic [SW-1:0] w_octs64;
    logic [TW-1:0] w_tick_next;
    logic [TW-1:0] w_len;
    logic          w_roll;

    // table port
    logic [IW-1:0]     w_addr;
    shts_pkg::t_tbl_we w_we;
    logic [CB-1:0]     w_wd_cur;
    logic [CB-1:0]     w_wd_prev;
    logic              w_rd_valid;
    logic [CB-1:0]     w_rd_cur;
    logic [CB-1:0]     w_rd_prev;

    // shared arithmetic
    logic              w_hit;
    logic [CB:0]       w_cur_sum;
    logic [CB-1:0]     w_cur_sat;
    logic [SW:0]       w_walk_sum;
    logic [CB-1:0]     w_mul_x;
    logic [AL-1:0]     w_mul_y;
    logic [PW-1:0]     w_prod;
    logic              w_div_start;
    logic              w_div_done;
    logic [SW-1:0]     w_quo;
    logic              w_out_free;

    function automatic logic in_net(input logic [31:0] ip, input logic [31:0] mask,
                                    input logic [31:0] base);
        in_net = (ip & mask) == base;
    endfunction

    function automatic logic host_fits(input logic [31:0] ip, input logic [31:0] mask);
        host_fits = {1'b0, ip & ~mask} < HOST_LIM;
    endfunction

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_state != S_IDLE;
    assign w_out_free = !o_out_valid || !i_out_stall;

    assign w_src_in  = in_net(i_in_req.src_ip, r_mask, r_base);
    assign w_src_fit = host_fits(i_in_req.src_ip, r_mask);
    assign w_dst_in  = in_net(i_in_req.dst_ip, r_mask, r_base);
    assign w_dst_fit = host_fits(i_in_req.dst_ip, r_mask);
    assign w_q_in    = in_net(i_in_req.query_ip, r_mask, r_base);
    assign w_q_fit   = host_fits(i_in_req.query_ip, r_mask);

    assign w_octs64    = SW'(i_in_req.flow_octets);
    assign w_tick_next = r_tick + 1'b1;
    assign w_len       = (r_interval == '0) ? TW'(1) : r_interval;
    assign w_roll      = w_tick_next >= w_len;

    assign w_alpha_wr = (i_cfg_data[AL-1:0] > shts_pkg::ALPHA_ONE) ?
                        shts_pkg::ALPHA_ONE : i_cfg_data[AL-1:0];

    // saturating adders: counter update on flows, idle sum on the walk
    assign w_cur_sum  = {1'b0, w_rd_cur} + {1'b0, r_octs};
    assign w_cur_sat  = w_cur_sum[CB] ? {CB{1'b1}} : w_cur_sum[CB-1:0];
    assign w_walk_sum = {1'b0, r_sum} + {1'b0, SW'(w_rd_cur)};

    // one multiplier serves both terms of the moving average
    assign w_mul_x = (r_state == S_BL1) ? r_sample : r_avg;
    assign w_mul_y = (r_state == S_BL1) ? r_alpha : shts_pkg::ALPHA_ONE - r_alpha;
    assign w_prod  = PW'(w_mul_x) * PW'(w_mul_y);

    assign w_hit       = r_phase ? r_dst_hit : r_src_hit;
    assign w_div_start = (r_state == S_DIVS) && (r_idle != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= shts_pkg::RST_SUBNET_BASE;
            r_mask     <= shts_pkg::RST_SUBNET_MASK;
            r_interval <= shts_pkg::RST_INTERVAL_MS;
            r_alpha    <= shts_pkg::RST_ALPHA_Q8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                shts_pkg::CFG_SUBNET_BASE: r_base     <= i_cfg_data;
                shts_pkg::CFG_SUBNET_MASK: r_mask     <= i_cfg_data;
                shts_pkg::CFG_INTERVAL_MS: r_interval <= i_cfg_data[TW-1:0];
                shts_pkg::CFG_ALPHA_Q8:    r_alpha    <= w_alpha_wr;
                default: ;
            endcase
        end
    end

    // table port control
    always_comb begin
        w_addr    = r_walk_idx;
        w_we      = '0;
        w_wd_cur  = w_cur_sat;
        w_wd_prev = '0;
        case (r_state)
            S_CLR: begin
                w_we.valid_we = 1'b1;
            end
            S_FRD: begin
                w_addr = r_phase ? r_dst_idx : r_src_idx;
            end
            S_FWR: begin
                w_addr         = r_phase ? r_dst_idx : r_src_idx;
                w_we.valid_we  = 1'b1;
                w_we.valid_val = 1'b1;
                w_we.cur_we    = 1'b1;
                if (!w_rd_valid) begin
                    // new entry: start from this flow, nothing last interval
                    w_wd_cur    = r_octs;
                    w_we.prev_we = 1'b1;
                end
            end
            S_QRD: begin
                w_addr = r_src_idx;
            end
            S_WWR: begin
                if (w_rd_valid) begin
                    w_we.cur_we  = 1'b1;
                    w_we.prev_we = 1'b1;
                    w_wd_cur     = '0;
                    w_wd_prev    = w_rd_cur;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_walk_idx == LAST_IDX) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_req.req_type)
                        shts_pkg::REQ_FLOW:
                            n_state = i_in_req.is_flow_record ? S_FRD : S_DONE;
                        shts_pkg::REQ_TICK:
                            n_state = w_roll ? S_WRD : S_DONE;
                        shts_pkg::REQ_QUERY:
                            n_state = (w_q_in && w_q_fit) ? S_QRD : S_DONE;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_FRD: begin
                if (w_hit) n_state = S_FWR;
                else if (r_phase) n_state = S_DONE;
            end
            S_FWR:  n_state = r_phase ? S_DONE : S_FRD;
            S_WRD:  n_state = S_WWR;
            S_WWR:  n_state = (r_walk_idx == LAST_IDX) ? S_DIVS : S_WRD;
            S_DIVS: n_state = (r_idle != '0) ? S_DIVW : S_BL1;
            S_DIVW: if (w_div_done) n_state = S_BL1;
            S_BL1:  n_state = S_BL2;
            S_BL2:  n_state = S_BL3;
            S_BL3:  n_state = S_DONE;
            S_QRD:  n_state = S_QRES;
            S_QRES: n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_walk_idx  <= '0;
            r_tick      <= '0;
            r_avg       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLR: r_walk_idx <= (r_walk_idx == LAST_IDX) ? '0 : r_walk_idx + 1'b1;
                S_IDLE: begin
                    if (w_accept && i_in_req.req_type == shts_pkg::REQ_TICK) begin
                        r_tick     <= w_roll ? '0 : w_tick_next;
                        r_walk_idx <= '0;
                    end
                end
                S_WWR: r_walk_idx <= (r_walk_idx == LAST_IDX) ? '0 : r_walk_idx + 1'b1;
                S_BL3: r_avg <= r_acc[CB+FR-1:FR];
                default: ;
            endcase
            if (r_state == S_DONE && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // working data
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_found   <= 1'b0;
                    r_host    <= '0;
                    r_rolled  <= 1'b0;
                    r_phase   <= 1'b0;
                    r_sum     <= '0;
                    r_idle    <= '0;
                    r_octs    <= CB'((w_octs64 > CNT_MAX) ? CNT_MAX : w_octs64);
                    r_src_hit <= w_src_in && w_src_fit;
                    r_dst_hit <= w_dst_in && w_dst_fit;
                    r_dst_idx <= i_in_req.dst_ip[IW-1:0] & ~r_mask[IW-1:0];
                    if (i_in_req.req_type == shts_pkg::REQ_QUERY) begin
                        r_src_idx <= i_in_req.query_ip[IW-1:0] & ~r_mask[IW-1:0];
                        r_oor     <= w_q_in && !w_q_fit;
                    end else begin
                        r_src_idx <= i_in_req.src_ip[IW-1:0] & ~r_mask[IW-1:0];
                        r_oor     <= (i_in_req.req_type == shts_pkg::REQ_FLOW) &&
                                     i_in_req.is_flow_record &&
                                     ((w_src_in && !w_src_fit) || (w_dst_in && !w_dst_fit));
                    end
                end
            end
            S_FRD: if (!w_hit && !r_phase) r_phase <= 1'b1;
            S_FWR: r_phase <= 1'b1;
            S_WWR: begin
                if (w_rd_valid) begin
                    if (w_rd_prev == '0) begin
                        r_idle <= r_idle + 1'b1;
                        r_sum  <= w_walk_sum[SW] ? {SW{1'b1}} : w_walk_sum[SW-1:0];
                    end
                end
            end
            S_DIVS: if (r_idle == '0) r_sample <= '0;
            S_DIVW: begin
                if (w_div_done) begin
                    r_sample <= CB'((w_quo > CNT_MAX) ? CNT_MAX : w_quo);
                end
            end
            S_BL1: r_acc <= AW'(w_prod);
            S_BL2: r_acc <= r_acc + AW'(w_prod);
            S_BL3: r_rolled <= 1'b1;
            S_QRES: begin
                if (w_rd_valid) begin
                    r_found <= 1'b1;
                    r_host  <= OW'(w_rd_prev);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_out_res.found           <= r_found;
                    o_out_res.host_octets     <= r_host;
                    o_out_res.zero_avg_octets <= OW'(r_avg);
                    o_out_res.rolled_over     <= r_rolled;
                    o_out_res.out_of_range    <= r_oor;
                end
            end
            default: ;
        endcase
    end

    shts_table #(
        .HOST_ENTRIES (HOST_ENTRIES),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_addr     (w_addr),
        .i_we       (w_we),
        .i_wd_cur   (w_wd_cur),
        .i_wd_prev  (w_wd_prev),
        .o_rd_valid (w_rd_valid),
        .o_rd_cur   (w_rd_cur),
        .o_rd_prev  (w_rd_prev)
    );

    shts_div #(
        .DIVISOR_BITS (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_idle),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accepted request did not start work");

    a_found_not_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.found |-> !o_out_res.out_of_range && !o_out_res.rolled_over)
        else $error("found result also flagged as range error or rollover");

    a_idle_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIVS |-> r_idle <= CW'(HOST_ENTRIES))
        else $error("idle host count exceeds table depth");

    a_div_to_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIVW && w_div_done |=> r_state == S_BL1)
        else $error("divider finished outside the average update");

endmodule
`default_nettype wire

@@ bench/tb_subnet_host_traffic_stats_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subnet host traffic statistics - testbench
// Drives flow records, millisecond ticks and host queries through the request
// channel under several subnet, interval and weight settings. Results not fixed
// by a directed row are checked against an in-bench model of the host table, the
// interval rollover and the idle-host moving average. Random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_subnet_host_traffic_stats_top;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         DRAIN_CYCLES = 2 * shts_pkg::HOST_ENTRIES_DEF + 80;
    localparam int         MIX_W        = shts_pkg::SUM_W + shts_pkg::ALPHA_W + 8;
    localparam int         HOSTS        = shts_pkg::HOST_ENTRIES_DEF;
    localparam int         IP_W         = shts_pkg::IP_W;
    localparam int         OCT_W        = shts_pkg::OCT_W;
    localparam int         OUT_W        = shts_pkg::OUT_W;
    localparam int         SUM_W        = shts_pkg::SUM_W;
    localparam int         TICK_W       = shts_pkg::TICK_W;
    localparam int         ALPHA_W      = shts_pkg::ALPHA_W;
    localparam int         ALPHA_FR     = shts_pkg::ALPHA_FR;
    localparam int         CFG_IDX_W    = shts_pkg::CFG_IDX_W;
    localparam int         CFG_DAT_W    = shts_pkg::CFG_DAT_W;

    typedef enum {HOST_OUTSIDE, HOST_IN_TABLE, HOST_TOO_HIGH} host_place_e;

    typedef struct {
        bit                   is_reg_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DAT_W-1:0] reg_val;
        shts_pkg::t_req       req;
        bit                   has_fixed;
        shts_pkg::t_res       fixed;
    } stim_row_t;

    typedef struct {
        logic [IP_W-1:0]    base;
        logic [IP_W-1:0]    mask;
        logic [TICK_W-1:0]  interval;
        logic [ALPHA_W-1:0] alpha;
        int                 count;
        int                 idle_mode;
        bit                 burst;
    } phase_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    shts_pkg::t_req       i_in_req;
    logic                 o_out_valid;
    logic                 i_out_stall;
    shts_pkg::t_res       o_out_res;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // host table model and its registers
    bit                 tbl_valid [HOSTS];
    logic [OUT_W-1:0]   tbl_cur   [HOSTS];
    logic [OUT_W-1:0]   tbl_prev  [HOSTS];
    logic [OUT_W-1:0]   idle_avg = '0;
    logic [TICK_W-1:0]  tick_cnt = '0;
    logic [IP_W-1:0]    cfg_base = shts_pkg::RST_SUBNET_BASE;
    logic [IP_W-1:0]    cfg_mask = shts_pkg::RST_SUBNET_MASK;
    logic [TICK_W-1:0]  cfg_interval = shts_pkg::RST_INTERVAL_MS;
    logic [ALPHA_W-1:0] cfg_alpha = shts_pkg::RST_ALPHA_Q8;

    shts_pkg::t_res pending_results [$];
    stim_row_t      stim_table [$];
    phase_t         phases [$];
    int             fail_count = 0;
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    shts_pkg::t_res got_want;

    subnet_host_traffic_stats_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic host_place_e place_host(input logic [IP_W-1:0] ip, output int idx);
        logic [IP_W-1:0] host;
        idx = 0;
        if ((ip & cfg_mask) != cfg_base) return HOST_OUTSIDE;
        host = ip & ~cfg_mask;
        if (host >= HOSTS) return HOST_TOO_HIGH;
        idx = int'(host);
        return HOST_IN_TABLE;
    endfunction

    // returns 1 when the address is in the subnet but past the table
    function automatic bit credit_host(input logic [IP_W-1:0] ip,
                                       input logic [OCT_W-1:0] octs);
        int              idx;
        logic [OUT_W:0]  total;
        case (place_host(ip, idx))
            HOST_TOO_HIGH: return 1'b1;
            HOST_IN_TABLE: begin
                if (!tbl_valid[idx]) begin
                    tbl_valid[idx] = 1'b1;
                    tbl_cur[idx]   = OUT_W'(octs);
                    tbl_prev[idx]  = '0;
                end else begin
                    total = {1'b0, tbl_cur[idx]} + octs;
                    tbl_cur[idx] = total[OUT_W] ? '1 : total[OUT_W-1:0];
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic shts_pkg::t_res stats_result(input shts_pkg::t_req r);
        shts_pkg::t_res    res;
        int                idx;
        int                idle_hosts;
        bit                far_src;
        bit                far_dst;
        logic [TICK_W-1:0] span;
        logic [SUM_W:0]    idle_sum;
        logic [SUM_W-1:0]  sample;
        logic [MIX_W-1:0]  mix;
        res = '0;
        case (r.req_type)
            shts_pkg::REQ_FLOW: begin
                if (r.is_flow_record) begin
                    far_src = credit_host(r.src_ip, r.flow_octets);
                    far_dst = credit_host(r.dst_ip, r.flow_octets);
                    res.out_of_range = far_src | far_dst;
                end
            end
            shts_pkg::REQ_TICK: begin
                span = (cfg_interval == '0) ? TICK_W'(1) : cfg_interval;
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= span) begin
                    tick_cnt   = '0;
                    idle_hosts = 0;
                    idle_sum   = '0;
                    // sum current octets of hosts idle last interval, then commit
                    for (int i = 0; i < HOSTS; i++) begin
                        if (tbl_valid[i]) begin
                            if (tbl_prev[i] == '0) begin
                                idle_hosts++;
                                idle_sum = idle_sum + tbl_cur[i];
                                if (idle_sum[SUM_W]) idle_sum = {1'b0, {SUM_W{1'b1}}};
                            end
                            tbl_prev[i] = tbl_cur[i];
                            tbl_cur[i]  = '0;
                        end
                    end
                    sample = (idle_hosts > 0) ? idle_sum[SUM_W-1:0] / SUM_W'(idle_hosts) : '0;
                    if (sample[SUM_W-1:OUT_W] != '0) sample = SUM_W'({OUT_W{1'b1}});
                    mix = MIX_W'(sample) * MIX_W'(cfg_alpha)
                        + MIX_W'(idle_avg) * MIX_W'(shts_pkg::ALPHA_ONE - cfg_alpha);
                    idle_avg = mix[OUT_W+ALPHA_FR-1:ALPHA_FR];
                    res.rolled_over = 1'b1;
                end
            end
            shts_pkg::REQ_QUERY: begin
                case (place_host(r.query_ip, idx))
                    HOST_TOO_HIGH: res.out_of_range = 1'b1;
                    HOST_IN_TABLE: begin
                        if (tbl_valid[idx]) begin
                            res.found       = 1'b1;
                            res.host_octets = tbl_prev[idx];
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.zero_avg_octets = idle_avg;
        return res;
    endfunction

    function automatic logic [IP_W-1:0] pick_address();
        int              pick;
        logic [IP_W-1:0] host;
        pick = $urandom_range(99);
        if (pick < 55) host = $urandom_range(15);
        else if (pick < 75) host = $urandom_range(255);
        else if (pick < 85) host = $urandom;
        else return $urandom;
        return (cfg_base & cfg_mask) | (host & ~cfg_mask);
    endfunction

    function automatic void add_request(input logic [1:0] kind, input logic flag,
                                        input logic [IP_W-1:0] src, input logic [IP_W-1:0] dst,
                                        input logic [OCT_W-1:0] octs,
                                        input logic [IP_W-1:0] qip, input bit fixed,
                                        input logic fnd, input logic [OUT_W-1:0] hoct,
                                        input logic oor);
        stim_row_t row;
        row = '{default: '0};
        row.req.req_type       = kind;
        row.req.is_flow_record = flag;
        row.req.src_ip         = src;
        row.req.dst_ip         = dst;
        row.req.flow_octets    = octs;
        row.req.query_ip       = qip;
        row.has_fixed          = fixed;
        row.fixed.found        = fnd;
        row.fixed.host_octets  = hoct;
        row.fixed.out_of_range = oor;
        stim_table.push_back(row);
    endfunction

    function automatic void add_reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] val);
        stim_row_t row;
        row = '{default: '0};
        row.is_reg_write = 1'b1;
        row.reg_idx      = idx;
        row.reg_val      = val;
        stim_table.push_back(row);
    endfunction

    function automatic void add_phase(input logic [IP_W-1:0] base, input logic [IP_W-1:0] mask,
                                      input logic [TICK_W-1:0] interval,
                                      input logic [ALPHA_W-1:0] alpha, input int count,
                                      input int idle_mode, input bit burst);
        phase_t ph;
        ph.base      = base;
        ph.mask      = mask;
        ph.interval  = interval;
        ph.alpha     = alpha;
        ph.count     = count;
        ph.idle_mode = idle_mode;
        ph.burst     = burst;
        phases.push_back(ph);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            shts_pkg::CFG_SUBNET_BASE: cfg_base = val;
            shts_pkg::CFG_SUBNET_MASK: cfg_mask = val;
            shts_pkg::CFG_INTERVAL_MS: cfg_interval = val[TICK_W-1:0];
            shts_pkg::CFG_ALPHA_Q8:
                cfg_alpha = (val[ALPHA_W-1:0] > shts_pkg::ALPHA_ONE) ? shts_pkg::ALPHA_ONE
                                                                      : val[ALPHA_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // valid stays high on return; the next call or a drain decides its level
    task automatic send_request(input shts_pkg::t_req r, input shts_pkg::t_res want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n ? ($urandom_range(99) < stall_pct) : 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result %h at %0t", o_out_res, $time);
            end else begin
                got_want = pending_results.pop_front();
                if (got_want.found !== o_out_res.found
                        || got_want.host_octets !== o_out_res.host_octets
                        || got_want.zero_avg_octets !== o_out_res.zero_avg_octets
                        || got_want.rolled_over !== o_out_res.rolled_over
                        || got_want.out_of_range !== o_out_res.out_of_range) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch at %0t: found/host/avg/roll/oor", $time);
                        $display("  expected %b %h %h %b %b", got_want.found,
                                 got_want.host_octets, got_want.zero_avg_octets,
                                 got_want.rolled_over, got_want.out_of_range);
                        $display("  actual   %b %h %h %b %b", o_out_res.found,
                                 o_out_res.host_octets, o_out_res.zero_avg_octets,
                                 o_out_res.rolled_over, o_out_res.out_of_range);
                    end
                end
            end
        end
    end

    initial begin
        #(60_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        shts_pkg::t_req  req;
        shts_pkg::t_res  want;
        stim_row_t       row;
        phase_t          ph;
        logic [IP_W-1:0] burst_ip;
        int              pick;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        i_out_stall = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;

        // directed part, reset settings: subnet 0.0.0.0/24, long interval
        add_request(shts_pkg::REQ_QUERY, 1'b0, '0, '0, '0, 32'h0000_0005,
                    1, 1'b0, '0, 1'b0);
        add_request(shts_pkg::REQ_TICK, 1'b0, '0, '0, '0, '0, 1, 1'b0, '0, 1'b0);
        add_request(REQ_UNUSED, 1'b1, '1, '1, '1, '1, 1, 1'b0, '0, 1'b0);
        add_request(shts_pkg::REQ_FLOW, 1'b0, 32'h0000_0001, 32'h0000_0002, '1, '0,
                    1, 1'b0, '0, 1'b0);
        add_request(shts_pkg::REQ_FLOW, 1'b1, 32'h0000_0001, 32'h0000_0002, '1, '0,
                    1, 1'b0, '0, 1'b0);
        add_request(shts_pkg::REQ_FLOW, 1'b1, 32'h0000_0003, 32'h0000_0003, 40'd100, '0,
                    1, 1'b0, '0, 1'b0);
        add_request(shts_pkg::REQ_FLOW, 1'b1, 32'h0A00_0001, 32'h0000_0001, '0, '0,
                    1, 1'b0, '0, 1'b0);
        add_request(shts_pkg::REQ_QUERY, 1'b0, '0, '0, '0, 32'h0000_0001,
                    1, 1'b1, '0, 1'b0);
        add_request(shts_pkg::REQ_QUERY, 1'b0, '0, '0, '0, 32'hFFFF_FFFF,
                    1, 1'b0, '0, 1'b0);
        add_reg_row(shts_pkg::CFG_SUBNET_MASK, 32'hFFFF_FE00);
        add_request(shts_pkg::REQ_FLOW, 1'b1, 32'h0000_0100, 32'h0000_0001, 40'd5, '0,
                    1, 1'b0, '0, 1'b1);
        add_request(shts_pkg::REQ_QUERY, 1'b0, '0, '0, '0, 32'h0000_01FF,
                    1, 1'b0, '0, 1'b1);
        add_request(shts_pkg::REQ_QUERY, 1'b0, '0, '0, '0, 32'h0000_0002,
                    1, 1'b1, '0, 1'b0);
        add_reg_row(shts_pkg::CFG_INTERVAL_MS, 32'd0);
        add_request(shts_pkg::REQ_TICK, 1'b0, '0, '0, '0, '0, 0, 1'b0, '0, 1'b0);
        add_request(shts_pkg::REQ_QUERY, 1'b0, '0, '0, '0, 32'h0000_0001,
                    0, 1'b0, '0, 1'b0);
        add_request(shts_pkg::REQ_QUERY, 1'b0, '0, '0, '0, 32'h0000_0003,
                    0, 1'b0, '0, 1'b0);
        add_reg_row(shts_pkg::CFG_ALPHA_Q8, 32'd300);
        add_request(shts_pkg::REQ_FLOW, 1'b1, 32'h0000_0000, 32'h0000_01FE, '0, '0,
                    0, 1'b0, '0, 1'b0);
        add_request(shts_pkg::REQ_TICK, 1'b0, '0, '0, '0, '0, 0, 1'b0, '0, 1'b0);
        add_reg_row(shts_pkg::CFG_ALPHA_Q8, 32'd0);
        add_request(shts_pkg::REQ_TICK, 1'b0, '0, '0, '0, '0, 0, 1'b0, '0, 1'b0);
        add_request(shts_pkg::REQ_QUERY, 1'b0, '0, '0, '0, 32'h0000_0000,
                    0, 1'b0, '0, 1'b0);

        add_phase(32'h0A00_0100, 32'hFFFF_FF00, 16'd3, 9'd26, 150, 0, 0);
        add_phase(32'hC0A8_0000, 32'hFFFF_FE00, 16'd1, 9'd256, 150, 0, 0);
        add_phase(32'hAC10_0000, 32'hFFF0_0000, 16'd5, 9'd0, 120, 0, 0);
        add_phase(32'h0A00_0100, 32'hFFFF_FF00, 16'd1, 9'd128, 134, 1, 1);
        add_phase(32'h7F00_0001, 32'hFFFF_FFFF, 16'd2, 9'd300, 100, 1, 0);
        add_phase(32'h0000_0000, 32'h0000_0000, 16'd0, 9'd511, 100, 1, 0);
        add_phase(32'h0A0A_0A80, 32'hFFFF_FF80, 16'd65535, 9'd1, 150, 2, 0);
        add_phase(32'h0A00_0155, 32'hFFFF_FF00, 16'd2, 9'd200, 60, 2, 0);
        add_phase(32'hFFFF_FF00, 32'hFFFF_FF00, 16'd4, 9'd77, 100, 2, 0);

        send_idle_pct = 15;
        stall_pct     = 83;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_table[k]) begin
            row = stim_table[k];
            if (row.is_reg_write) begin
                wait_drained();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                want = stats_result(row.req);
                if (row.has_fixed) want = row.fixed;
                send_request(row.req, want);
            end
        end

        foreach (phases[p]) begin
            ph = phases[p];
            wait_drained();
            case (ph.idle_mode)
                0: begin
                    send_idle_pct = 15;
                    stall_pct     = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    stall_pct     = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            write_reg(shts_pkg::CFG_SUBNET_BASE, ph.base);
            write_reg(shts_pkg::CFG_SUBNET_MASK, ph.mask);
            write_reg(shts_pkg::CFG_INTERVAL_MS, CFG_DAT_W'(ph.interval));
            write_reg(shts_pkg::CFG_ALPHA_Q8, CFG_DAT_W'(ph.alpha));
            burst_ip = (cfg_base & cfg_mask) | 32'd7;
            for (int n = 0; n < ph.count; n++) begin
                if (ph.burst) begin
                    // drive one host past the counter limit, then roll and read it back
                    req.is_flow_record = 1'b1;
                    req.src_ip         = burst_ip;
                    req.dst_ip         = burst_ip;
                    req.query_ip       = burst_ip;
                    req.flow_octets    = '1;
                    if (n < ph.count - 4) req.req_type = shts_pkg::REQ_FLOW;
                    else if (n % 2 == 0) req.req_type = shts_pkg::REQ_TICK;
                    else req.req_type = shts_pkg::REQ_QUERY;
                end else begin
                    req.src_ip   = pick_address();
                    req.dst_ip   = ($urandom_range(19) == 0) ? req.src_ip : pick_address();
                    req.query_ip = pick_address();
                    req.is_flow_record = ($urandom_range(9) != 0);
                    pick = $urandom_range(99);
                    if (pick < 45) req.req_type = shts_pkg::REQ_FLOW;
                    else if (pick < 62) req.req_type = shts_pkg::REQ_TICK;
                    else if (pick < 95) req.req_type = shts_pkg::REQ_QUERY;
                    else req.req_type = REQ_UNUSED;
                    pick = $urandom_range(9);
                    if (pick == 0) req.flow_octets = '1;
                    else if (pick == 1) req.flow_octets = OCT_W'($urandom_range(3));
                    else req.flow_octets = {8'($urandom), $urandom};
                end
                send_request(req, stats_result(req));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) fail_count++;
        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ subnet_host_traffic_stats_top.f @@
rtl/shts_pkg.sv
rtl/shts_table.sv
rtl/shts_div.sv
rtl/subnet_host_traffic_stats_top.sv
bench/tb_subnet_host_traffic_stats_top.sv
